// ===== hdl/jos_pkg.sv =====
// ----------------------------------------------------------------------------
// jos_pkg
// Shared types and constants for the JSON object splitter: parse modes,
// status codes, delimiter bytes and the brace depth width.
// ----------------------------------------------------------------------------
package jos_pkg;

  // Brace depth counter width (4 to 32)
  localparam int unsigned DepthW   = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned LevelW   = 16;

  localparam logic [DepthW-1:0] DepthMax = {DepthW{1'b1}};

  // Delimiter bytes
  localparam logic [ByteW-1:0] ChOpen   = 8'h7B;
  localparam logic [ByteW-1:0] ChClose  = 8'h7D;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    ModeBetween = 2'd0,
    ModeObject  = 2'd1,
    ModeString  = 2'd2,
    ModeEscape  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StConsumed = 2'd0,
    StComplete = 2'd1,
    StUnexpect = 2'd2,
    StOverflow = 2'd3
  } status_e;

  // One result word
  typedef struct packed {
    status_e             status;
    logic [LevelW-1:0]   nest_level;
  } result_t;

  // Outcome of handling one byte
  typedef struct packed {
    mode_e               mode;
    logic [DepthW-1:0]   depth;
    result_t             res;
  } step_t;

endpackage

// ===== hdl/jos_step.sv =====
// ----------------------------------------------------------------------------
// jos_step
// Combinational parser step: from the current mode, brace depth and one
// byte, forms the next mode, the next depth and the result word.
// ----------------------------------------------------------------------------
module jos_step (
  input  jos_pkg::mode_e                 mode_i,
  input  logic [jos_pkg::DepthW-1:0]     depth_i,
  input  logic [jos_pkg::ByteW-1:0]      data_byte_i,
  output jos_pkg::step_t                 step_o
);
  import jos_pkg::*;

  logic              is_blank;
  logic [DepthW-1:0] depth_dec;
  mode_e             mode_n;
  logic [DepthW-1:0] depth_n;
  status_e           status_n;

  // Classify the byte and precompute the decremented depth
  assign is_blank  = (data_byte_i inside {ChSpace, [ChTab:ChCr]});
  assign depth_dec = (depth_i != '0) ? depth_i - DepthW'(1) : '0;

  // Advance the parse mode and brace depth
  always_comb begin
    mode_n   = mode_i;
    depth_n  = depth_i;
    status_n = StConsumed;
    case (mode_i)
      ModeBetween: begin
        if (data_byte_i == ChOpen) begin
          mode_n  = ModeObject;
          depth_n = DepthW'(1);
        end else if (!is_blank) begin
          status_n = StUnexpect;
        end
      end
      ModeObject: begin
        if (data_byte_i == ChOpen) begin
          if (depth_i == DepthMax) begin
            status_n = StOverflow;
          end else begin
            depth_n = depth_i + DepthW'(1);
          end
        end else if (data_byte_i == ChClose) begin
          depth_n = depth_dec;
          if (depth_dec == '0) begin
            status_n = StComplete;
            mode_n   = ModeBetween;
          end
        end else if (data_byte_i == ChQuote) begin
          mode_n = ModeString;
        end
      end
      ModeString: begin
        if (data_byte_i == ChQuote) begin
          mode_n = ModeObject;
        end else if (data_byte_i == ChBslash) begin
          mode_n = ModeEscape;
        end
      end
      default: begin
        mode_n = ModeString;
      end
    endcase
  end

  // Pack the outcome; show the low bits of the depth
  always_comb begin
    step_o                = '0;
    step_o.mode           = mode_n;
    step_o.depth          = depth_n;
    step_o.res.status     = status_n;
    step_o.res.nest_level = LevelW'(depth_n);
  end

endmodule

// ===== hdl/jos_out_buf.sv =====
// ----------------------------------------------------------------------------
// jos_out_buf
// Result register: holds one result word until the receiver takes it and
// tells the stage before it whether a new word can be loaded.
// ----------------------------------------------------------------------------
module jos_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  jos_pkg::result_t   res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jos_pkg::result_t   res_o
);
  import jos_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held word leaves this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture a new word on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/json_object_splitter_core.sv =====
// ----------------------------------------------------------------------------
// json_object_splitter_core
// Finds the end of each top-level JSON object in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one text byte per word.
//   Output channel (out_valid_o / out_ready_i) returns exactly one word per
//   byte: status_o (consumed, object complete, unexpected byte between
//   objects, depth overflow) and nest_level_o, the brace depth after the
//   byte, low 16 bits.
//   Path: an accepted byte goes into the input register, then through one
//   combinational parser step into the result register.
//   Throughput: one byte per cycle while out_ready_i stays high; the parse
//   mode and depth registers close a loop through the parser step.
//   Reset: rst_ni clears both pipeline registers' valid flags, puts the
//   parser in the between-objects mode and zeroes the depth.
//   Stall: while the receiver holds out_ready_i low, the result stays put;
//   one more byte is taken into the input register, then in_ready_o drops
//   until the result is taken.
// ----------------------------------------------------------------------------
module json_object_splitter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [jos_pkg::ByteW-1:0]      data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [jos_pkg::StatusW-1:0]    status_o,
  output logic [jos_pkg::LevelW-1:0]     nest_level_o
);
  import jos_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [ByteW-1:0]  byte_q;
  mode_e             mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              buf_free;
  logic              advance;
  step_t             step;
  result_t           res_out;

  // Move the held byte into the result register when there is room
  assign advance    = in_valid_q && buf_free;
  assign in_ready_o = !in_valid_q || buf_free;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !buf_free);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  jos_step u_step (
    .mode_i      (mode_q),
    .depth_i     (depth_q),
    .data_byte_i (byte_q),
    .step_o      (step)
  );

  // Update the parser state only when a byte is handled
  assign mode_d  = advance ? step.mode  : mode_q;
  assign depth_d = advance ? step.depth : depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBetween;
      depth_q <= '0;
    end else begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
    end
  end

  jos_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step.res),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign status_o     = StatusW'(res_out.status);
  assign nest_level_o = res_out.nest_level;

  // Between objects the depth is always zero
  a_between_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeBetween) |-> (depth_q == '0))
    else $error("depth nonzero between objects");

  // Inside an object the depth is never zero
  a_inside_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeBetween) |-> (depth_q != '0))
    else $error("depth zero inside an object");

  // A completed object reports depth zero
  a_complete_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_out.status == StComplete) |-> (nest_level_o == '0))
    else $error("object complete with nonzero depth");

  // An overflow report shows the saturated depth
  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_out.status == StOverflow)
      |-> (nest_level_o == LevelW'(DepthMax)))
    else $error("overflow without saturated depth");

  // Parser state holds when no byte is handled
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(mode_q) && $stable(depth_q)))
    else $error("parser state changed without a byte");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_object_splitter_core. A queue of text bytes
// feeds a valid/ready driver; a monitor tracks its own parser state, builds
// the expected status and nesting level for every accepted byte, and checks
// each returned word against the oldest one waiting. Both sides idle at
// random. The stimulus covers directed edge cases, one brace run nested far
// deeper than the random objects, and random well-formed objects with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import jos_pkg::*;

  // Control markers mixed into the byte queue
  localparam int DrainMark = -1;
  localparam int QuietMark = -2;
  // Nesting of the deep brace run
  localparam int DeepRun   = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [LevelW-1:0]  nest_level_o;

  // Byte source and expected results
  int      word_q[$];
  result_t due_results[$];
  int      bytes_total = 0;
  int      bytes_taken = 0;
  bit      byte_taken = 1'b0;
  bit      idle_on = 1'b1;
  int      send_gap = 0;
  int      recv_stall = 0;

  // Parser state tracked by the bench
  mode_e             pmode = ModeBetween;
  logic [DepthW-1:0] pdepth = '0;

  // Run statistics
  int      errors = 0;
  int      words_checked = 0;
  int      objects_closed = 0;
  int      stray_bytes = 0;
  int      overflows = 0;
  int      deepest = 0;
  result_t due;

  json_object_splitter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .nest_level_o (nest_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_blank(input logic [ByteW-1:0] b);
    return b == ChSpace || (b >= ChTab && b <= ChCr);
  endfunction

  // Advance the tracked parser by one byte and return the word it should give
  function automatic result_t split_step(input logic [ByteW-1:0] b);
    result_t r;
    r.status = StConsumed;
    case (pmode)
      ModeBetween: begin
        if (b == ChOpen) begin
          pmode  = ModeObject;
          pdepth = DepthW'(1);
        end else if (!is_blank(b)) begin
          r.status = StUnexpect;
        end
      end
      ModeObject: begin
        if (b == ChOpen) begin
          if (pdepth == DepthMax) r.status = StOverflow;
          else pdepth = pdepth + 1'b1;
        end else if (b == ChClose) begin
          if (pdepth != '0) pdepth = pdepth - 1'b1;
          if (pdepth == '0) begin
            r.status = StComplete;
            pmode    = ModeBetween;
          end
        end else if (b == ChQuote) begin
          pmode = ModeString;
        end
      end
      ModeString: begin
        if (b == ChQuote) pmode = ModeObject;
        else if (b == ChBslash) pmode = ModeEscape;
      end
      default: pmode = ModeString;
    endcase
    r.nest_level = LevelW'(pdepth);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("tb: mismatch at %0t ns: %s", $time, msg);
  endtask

  // Stimulus helpers
  task automatic push_word(input int b);
    word_q.push_back(b);
    bytes_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i]);
  endtask

  function automatic int plain_byte();
    int b;
    do b = $urandom_range(0, 255);
    while (b == ChOpen || b == ChClose || b == ChQuote);
    return b;
  endfunction

  task automatic push_string();
    int n;
    int b;
    n = $urandom_range(0, 6);
    push_word(ChQuote);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        push_word(ChBslash);
        push_word($urandom_range(0, 255));
      end else begin
        do b = $urandom_range(0, 255);
        while (b == ChQuote || b == ChBslash);
        push_word(b);
      end
    end
    push_word(ChQuote);
  endtask

  task automatic push_object();
    int lvl;
    int pick;
    lvl = 1;
    push_word(ChOpen);
    while (lvl > 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        push_word(plain_byte());
      end else if (pick < 5) begin
        push_string();
      end else if (pick < 7 && lvl < 8) begin
        push_word(ChOpen);
        lvl++;
      end else begin
        push_word(ChClose);
        lvl--;
      end
    end
  endtask

  task automatic push_gap();
    int v;
    repeat ($urandom_range(0, 3)) begin
      v = $urandom_range(9, 14);
      push_word(v == 14 ? int'(ChSpace) : v);
    end
    if ($urandom_range(0, 7) == 0) push_word(plain_byte());
  endtask

  // Broken fragment, heavy on delimiters
  task automatic push_noise();
    int pick;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0:       push_word(ChOpen);
        1:       push_word(ChClose);
        2:       push_word(ChQuote);
        3:       push_word(ChBslash);
        default: push_word($urandom_range(0, 255));
      endcase
    end
  endtask

  // Driver: present the next queued byte at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      byte_taken = 1'b0;
      while (word_q.size() != 0 && word_q[0] < 0 &&
             !(word_q[0] == DrainMark && due_results.size() != 0)) begin
        if (word_q[0] == QuietMark) idle_on = 1'b0;
        void'(word_q.pop_front());
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() == 0 || word_q[0] < 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i  <= 1'b1;
        data_byte_i <= ByteW'(word_q.pop_front());
        if (idle_on && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 13);
      end
    end
  end

  // Receiver: stall the result channel in random bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_on && $urandom_range(0, 15) == 0) recv_stall = $urandom_range(1, 13);
      end
    end
  end

  // Monitor: check returned words, then record accepted bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("word with none pending: status %0d level %0d",
                                    status_o, nest_level_o));
        end else begin
          due = due_results.pop_front();
          words_checked++;
          if (status_o !== due.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status_o, due.status));
          if (nest_level_o !== due.nest_level)
            report_mismatch($sformatf("nest level %0d, predicted %0d",
                                      nest_level_o, due.nest_level));
          case (due.status)
            StComplete: objects_closed++;
            StUnexpect: stray_bytes++;
            StOverflow: overflows++;
            default: ;
          endcase
          if (int'(due.nest_level) > deepest) deepest = int'(due.nest_level);
        end
      end
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(split_step(data_byte_i));
        bytes_taken++;
        byte_taken = 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Directed: every blank, stray bytes, escaped quote, braces in a string
    for (int c = int'(ChTab); c <= int'(ChCr); c++) push_word(c);
    push_word(ChSpace);
    push_word(8'h00);
    push_word(8'hFF);
    push_word(ChClose);
    push_word(8'h08);
    push_word(8'h0E);
    push_word(8'h21);
    push_text("{\"\\\"{}\"}");
    push_text("{{}}");

    // Deep brace run with braces inside a string at the bottom, then unwind
    word_q.push_back(DrainMark);
    repeat (DeepRun) push_word(ChOpen);
    push_text("\"{}\"");
    repeat (DeepRun) push_word(ChClose);
    word_q.push_back(DrainMark);

    // Random: mostly well-formed objects, some noise and broken fragments
    for (int n = 0; n < 1400; ) begin
      int start;
      start = bytes_total;
      push_gap();
      if ($urandom_range(0, 11) == 0) push_noise();
      else push_object();
      n += bytes_total - start;
      if (n > 700 && n - (bytes_total - start) <= 700) word_q.push_back(DrainMark);
    end

    // Tail without idling
    word_q.push_back(QuietMark);
    repeat (4) begin
      push_gap();
      push_object();
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (bytes_taken != bytes_total || due_results.size() != 0);
    repeat (6) @(posedge clk_i);

    $display("tb: %0d bytes sent, %0d words checked, %0d mismatches",
             bytes_total, words_checked, errors);
    $display("tb: %0d objects closed, %0d stray bytes, %0d overflows, deepest level %0d",
             objects_closed, stray_bytes, overflows, deepest);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("tb: watchdog expired");
    $display("tb: failure");
    $finish;
  end

endmodule
